/* sv/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_WRDS = 16;
    localparam int unsigned HASH_WRDS  = 8;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;

    typedef logic [WORD_W-1:0] word_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // byte source for the buffer write
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      put_byte;
        byte_src_t src;
        logic      add_bits;
        logic      round_load;
        logic      round_step;
        logic      hash_update;
        logic      finish;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round_idx;
    } dp_status_t;

    localparam word_t INIT_HASH [HASH_WRDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int unsigned n);
        ror = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

`default_nettype wire

/* sv/sha256_if.sv */
// ----------------------------------------------------------------------------
// sha256_byte_if / sha256_digest_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, data_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

/* sv/sha256_datapath.sv */
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, message schedule window, round unit and chaining hash.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sha256_pkg::dp_cmd_t    cmd,
    input  wire logic [7:0]             data_byte,
    input  wire logic [2:0]             emit_idx,
    output sha256_pkg::dp_status_t      status,
    output sha256_pkg::word_t           hash_word
);
    import sha256_pkg::*;

    word_t       buf_reg  [BLOCK_WRDS];
    word_t       w_reg    [BLOCK_WRDS];
    word_t       v_reg    [HASH_WRDS];
    word_t       h_reg    [HASH_WRDS];
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg;
    logic [63:0] bits_reg;
    logic [7:0]  wr_byte;
    logic [2:0]  len_sel;
    word_t       w_new, t1, t2;

    assign status.fill      = fill_reg;
    assign status.round_idx = rnd_reg;
    assign hash_word        = h_reg[emit_idx];

    // byte to write, length bytes taken big-endian from offset 56
    assign len_sel = fill_reg[2:0];
    always_comb
    begin
        unique case (cmd.src)
            SRC_DATA: wr_byte = data_byte;
            SRC_PAD:  wr_byte = PAD_BYTE;
            SRC_ZERO: wr_byte = 8'h00;
            SRC_LEN:  wr_byte = bits_reg[(3'd7 - len_sel) * 8 +: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    assign fill_next = fill_reg + 6'd1;

    // schedule word and round terms
    assign w_new = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[rnd_reg] + w_reg[0];
    assign t2 = bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < HASH_WRDS; i++)
                h_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            if (cmd.add_bits)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.put_byte)
                fill_reg <= fill_next;
            if (cmd.round_load)
                rnd_reg <= '0;
            else if (cmd.round_step)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.hash_update)
                for (int i = 0; i < HASH_WRDS; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.finish)
            begin
                bits_reg <= '0;
                fill_reg <= '0;
                for (int i = 0; i < HASH_WRDS; i++)
                    h_reg[i] <= INIT_HASH[i];
            end
        end
    end

    // buffer, schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
            buf_reg[fill_reg[5:2]][(2'd3 - fill_reg[1:0]) * 8 +: 8] <= wr_byte;
        if (cmd.round_load)
        begin
            for (int i = 0; i < BLOCK_WRDS; i++)
                w_reg[i] <= buf_reg[i];
            for (int i = 0; i < HASH_WRDS; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < BLOCK_WRDS - 1; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[BLOCK_WRDS-1] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

/* sv/sha256_ctrl.sv */
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for byte intake, padding, rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_has,
    input  wire logic                   in_last,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  emit_idx,
    output sha256_pkg::dp_cmd_t         cmd,
    input  wire sha256_pkg::dp_status_t status
);
    import sha256_pkg::*;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;      // 0x80 byte still to be written
    logic       spill_reg, spill_next;  // 0x80 landed at or past offset 56, length goes in next block
    logic       padding_reg, padding_next;  // message ended, padding under way
    logic       done_reg, done_next;    // length written, digest ready after compress
    logic [2:0] idx_reg, idx_next;

    assign emit_idx = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fin_reg     <= 1'b0;
            spill_reg   <= 1'b0;
            padding_reg <= 1'b0;
            done_reg    <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            spill_reg   <= spill_next;
            padding_reg <= padding_next;
            done_reg    <= done_next;
            idx_reg     <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        spill_next   = spill_reg;
        padding_next = padding_reg;
        done_next    = done_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.src      = SRC_DATA;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.put_byte = in_has;
                    cmd.add_bits = in_has;
                    fin_next     = in_last;
                    padding_next = in_last;
                    if (in_has && status.fill == 6'd63)
                        state_next = ST_LOAD;
                    else if (in_last)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // first pad byte is 0x80, then zeros, then the length
                cmd.put_byte = 1'b1;
                if (fin_reg)
                    cmd.src = SRC_PAD;
                else if (!spill_reg && status.fill >= LEN_POS)
                    cmd.src = SRC_LEN;
                else
                    cmd.src = SRC_ZERO;
                fin_next = 1'b0;
                if (status.fill == 6'd63)
                begin
                    spill_next = 1'b0;
                    if (!fin_reg && !spill_reg)
                        done_next = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (fin_reg && status.fill >= LEN_POS)
                    spill_next = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.round_load = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (status.round_idx == 6'(ROUNDS - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.hash_update = 1'b1;
                if (done_reg)
                    state_next = ST_EMIT;
                else if (padding_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.finish   = 1'b1;
                        padding_next = 1'b0;
                        done_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/sha256_message_digest.sv */
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream with a last flag; eight digest words out.
// ----------------------------------------------------------------------------
// Bytes are taken one a cycle while the 64-byte block fills; the byte that
// completes a block stalls the input through one load of the schedule
// window, 64 rounds of the single round unit and a hash update. On the last
// input beat the padding is written one byte a cycle into the block buffer,
// each padded block followed by a compression, one or two of them; then the
// eight digest words are offered in order, word 0 first, and the hash
// returns to its initial value. The input stays stalled from the last beat
// until the eighth digest word has gone.
`default_nettype none

module sha256_message_digest (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sha256_byte_if.sink     in_ch,
    sha256_digest_if.source out_ch
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] emit_idx;
    word_t      hash_word;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_has    (in_ch.has_byte),
        .in_last   (in_ch.last_byte),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .emit_idx  (emit_idx),
        .cmd       (cmd),
        .status    (status)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_ch.data_byte),
        .emit_idx  (emit_idx),
        .status    (status),
        .hash_word (hash_word)
    );

    // digest word output
    assign out_ch.digest_word = hash_word;
    assign out_ch.word_index  = emit_idx;
    assign out_ch.last_word   = (emit_idx == 3'd7);

endmodule

`default_nettype wire
